@@ hw/rtl/bb3_pkg.sv @@
// bb3_pkg: shared types and constants for the edge-aware 3x3 box blur.
// No dependencies; imported by every module of the block except bb3_ram.
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int NUM_SLOTS    = 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = 11;                    // image_width register
  localparam int HGT_W        = 13;                    // image_height register
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int SUM_W        = 12;                    // 9 * 255 fits
  localparam int CNT_W        = 4;                     // up to 9 pixels
  localparam int NUM_W        = SUM_W + 1;             // 2*sum + cnt
  localparam int PIX_W        = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_run;
    logic       image_done;
  } out_pixel_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;     // latch pixel, write line store, advance position
    logic       rd;         // read one neighbor column of the current result
    logic [1:0] col_j;      // column offset 0..2 (x-1 .. x+1)
    logic [1:0] res_k;      // {column select, row select} of the current result
    logic       div_load;
    logic       div_step;
    logic [2:0] div_bit;
    logic       emit;
    logic       last;
  } bb3_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] col_ok;     // [0]: left neighbor column, [1]: own column (row end)
    logic [1:0] row_ok;     // [0]: previous row, [1]: own row (last row)
    logic       out_free;
  } bb3_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/bb3_ram.sv @@
// bb3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/bb3_ctrl.sv @@
// bb3_ctrl: sequencer for the box blur; walks the results of one item.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bb3_ctrl
  import bb3_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire bb3_stat_t stat,
  output bb3_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PLAN  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_DIVL  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] j_r, j_nxt;
  logic [2:0] step_r, step_nxt;

  logic [3:0] res_ok;
  logic       first_found, more_found;
  logic [1:0] first_k, more_k;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res_ok[i] = stat.col_ok[i / 2] & stat.row_ok[i % 2];
    end
    first_found = 1'b0;
    first_k     = 2'd0;
    more_found  = 1'b0;
    more_k      = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (res_ok[i] && !first_found) begin
        first_found = 1'b1;
        first_k     = 2'(i);
      end
      if (res_ok[i] && (2'(i) > k_r) && !more_found) begin
        more_found = 1'b1;
        more_k     = 2'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.col_j    = j_r;
    cmd.res_k    = k_r;
    cmd.div_bit  = step_r;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PLAN;
        end
      end
      ST_PLAN: begin
        j_nxt = 2'd0;
        k_nxt = first_k;
        state_nxt = first_found ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        if (j_r == 2'd2) begin
          state_nxt = ST_FLUSH;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.div_load = 1'b1;
        step_nxt     = 3'd7;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == 3'd0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = !more_found;
          j_nxt    = 2'd0;
          k_nxt    = more_k;
          state_nxt = more_found ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 2'd0;
      j_r     <= 2'd0;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bb3_dpath.sv @@
// bb3_dpath: line store, position tracking, neighbor accumulation, divider
// and output register. Depends on bb3_pkg and bb3_ram.
`timescale 1ns / 1ps
`default_nettype none
module bb3_dpath
  import bb3_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_pixel_t             in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire bb3_cmd_t              cmd,
  output bb3_stat_t                  stat,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output out_pixel_t                 out_data
);

  // configuration and position
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [1:0]       slot_r;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [ROW_W-1:0] r_cl;
  logic [COL_W-1:0] c_cl;
  logic             c_last, r_last;

  // current item
  logic [ROW_W-1:0] r_cur_r;
  logic [COL_W-1:0] c_cur_r;
  logic [1:0]       s_cur_r;
  logic             clast_r, rlast_r;

  // column read and accumulation
  logic [COL_W-1:0] x_col;
  logic [WID_W-1:0] p1;
  logic             p_ok;
  logic [COL_W-1:0] raddr;
  logic             rd_v_r, rd_ok_r;
  logic [PIX_W-1:0] rdata [NUM_SLOTS];
  logic [2:0]       slot_use;
  logic [1:0]       n_rows;
  logic [SUM_W-1:0] sum_r [3];
  logic [SUM_W-1:0] sum_add [3];
  logic [CNT_W-1:0] cnt_r;

  // divider
  logic [NUM_W-1:0] rem_r [3];
  logic [4:0]       den_r;
  logic [7:0]       quo_r [3];
  logic [NUM_W-1:0] den_sh;

  logic             out_valid_r;
  out_pixel_t       out_r;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_r > HGT_W'(HEIGHT_LIMIT)) begin
      h_eff = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end
    r_cl   = (HGT_W'(row_r) >= h_eff) ? ROW_W'(h_eff - HGT_W'(1)) : row_r;
    c_cl   = (WID_W'(col_r) >= w_eff) ? COL_W'(w_eff - WID_W'(1)) : col_r;
    c_last = (WID_W'(c_cl) == w_eff - WID_W'(1));
    r_last = (HGT_W'(r_cl) == h_eff - HGT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(MAX_WIDTH);
      height_r <= HGT_W'(768);
      row_r    <= '0;
      col_r    <= '0;
      slot_r   <= 2'd0;
    end else if (cfg_valid &&
                 (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[WID_W-1:0];
      end else begin
        height_r <= cfg_data[HGT_W-1:0];
      end
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.accept) begin
      if (c_last) begin
        col_r  <= '0;
        slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
        row_r  <= r_last ? '0 : r_cl + ROW_W'(1);
      end else begin
        col_r <= c_cl + COL_W'(1);
        row_r <= r_cl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_cur_r <= r_cl;
      c_cur_r <= c_cl;
      s_cur_r <= slot_r;
      clast_r <= c_last;
      rlast_r <= r_last;
    end
  end

  assign stat.col_ok   = {clast_r, (c_cur_r != '0)};
  assign stat.row_ok   = {rlast_r, (r_cur_r != '0)};
  assign stat.out_free = !out_valid_r || !out_stall;

  // neighbor column p = x - 1 + j, carried as p + 1 to stay unsigned
  always_comb begin
    x_col = cmd.res_k[1] ? c_cur_r : c_cur_r - COL_W'(1);
    p1    = WID_W'(x_col) + WID_W'(cmd.col_j);
    p_ok  = (p1 != '0) && (p1 <= w_eff);
    raddr = COL_W'(p1 - WID_W'(1));
  end

  for (genvar m = 0; m < NUM_SLOTS; m++) begin : g_line
    bb3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.accept && (slot_r == 2'(m))),
      .waddr (c_cl),
      .wdata (in_data),
      .raddr (raddr),
      .rdata (rdata[m])
    );
  end

  // slot m holds the row "back" rows older than the newest
  always_comb begin
    logic [1:0] back;
    for (int m = 0; m < NUM_SLOTS; m++) begin
      back = (s_cur_r >= 2'(m)) ? s_cur_r - 2'(m) : s_cur_r + 2'(NUM_SLOTS - m);
      slot_use[m] = (ROW_W'(back) <= r_cur_r) && (!cmd.res_k[0] || back <= 2'd1);
    end
    n_rows = 2'(slot_use[0]) + 2'(slot_use[1]) + 2'(slot_use[2]);
    for (int ch = 0; ch < 3; ch++) begin
      sum_add[ch] = sum_r[ch];
      for (int m = 0; m < NUM_SLOTS; m++) begin
        if (slot_use[m]) begin
          sum_add[ch] = sum_add[ch] + SUM_W'(rdata[m][PIX_W-1-8*ch -: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= p_ok;
    if (cmd.rd && cmd.col_j == 2'd0) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= '0;
      end
      cnt_r <= '0;
    end else if (rd_v_r && rd_ok_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= sum_add[ch];
      end
      cnt_r <= cnt_r + CNT_W'(n_rows);
    end
  end

  // restoring divide of (2*sum + cnt) by 2*cnt, one quotient bit a cycle
  assign den_sh = NUM_W'(den_r) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      den_r <= {cnt_r, 1'b0};
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch] <= {sum_r[ch], 1'b0} + NUM_W'(cnt_r);
        quo_r[ch] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= den_sh) begin
          rem_r[ch] <= rem_r[ch] - den_sh;
          quo_r[ch][cmd.div_bit] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_red     <= quo_r[0];
      out_r.out_green   <= quo_r[1];
      out_r.out_blue    <= quo_r[2];
      out_r.last_of_run <= cmd.last;
      out_r.image_done  <= cmd.last && clast_r && rlast_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ hw/rtl/box_blur_3x3_edge_aware.sv @@
// box_blur_3x3_edge_aware: top level of the edge-aware 3x3 box blur.
// Depends on bb3_pkg, bb3_ctrl and bb3_dpath.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | in_data  (in_pixel_t: red, green, blue)
//  out     | out_valid/out_stall| out_data (out_pixel_t: rgb, last_of_run,
//          |                    |           image_done)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (0: width, 1: height)
//
// An item goes through a plan step, then for each result it releases (0..4):
// 3 line-store reads (one column each, all three line slots at once), one
// flush, one load and 8 divider steps (one quotient bit each), then an output
// step that waits while the output is stalled.
// Reset is synchronous (rst_n low); the line store is not cleared.
// in_stall is high while an item is being worked on.
module box_blur_3x3_edge_aware
  import bb3_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_pixel_t             in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_pixel_t                 out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bb3_cmd_t  cmd;
  bb3_stat_t stat;

  // the user must write registers only while idle (the block does not enforce it), so always ready
  assign cfg_ready = 1'b1;

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bb3_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted item blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwrote a pending output");

  // the final pixel of an image always closes its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.image_done || out_data.last_of_run))
    else $error("image_done without last_of_run");

  // no item is accepted while results are still being computed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.div_step || cmd.emit) |-> !cmd.accept)
    else $error("accept during result sequence");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking regression for box_blur_3x3_edge_aware.
// Depends on bb3_pkg and the box_blur_3x3_edge_aware RTL; reads no files.
`timescale 1ns / 1ps

module tb;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 80;     // covers one item releasing four results

  // ---------------------------------------------------------------------------
  // Clock and DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_pixel_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_pixel_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  box_blur_3x3_edge_aware u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Blur predictor: own copy of registers, positions and the three line slots
  // ---------------------------------------------------------------------------
  logic [WID_W-1:0] width_reg  = 11'd1024;
  logic [HGT_W-1:0] height_reg = 13'd768;
  int               row_pos    = 0;
  int               col_pos    = 0;
  int               slot_pos   = 0;
  in_pixel_t        lines [NUM_SLOTS][MAX_WIDTH];

  out_pixel_t       blurred_q [$];      // expected results, oldest first

  int  mismatches = 0;
  int  cycles     = 0;
  int  hold_off   = 0;                  // long receiver stall, set by a test
  bit  send_calm  = 1'b0;               // stretches with no input gaps
  bit  recv_calm  = 1'b0;               // stretches with no output stalls

  // Mean over the in-image part of the 3x3 window around (t, x), using only
  // rows still held in the line slots while row r sits in slot s.
  function automatic out_pixel_t blur_at(int t, int x, int r, int s, int w, int h);
    int sr, sg, sb, cnt, q, p, sl;
    out_pixel_t o;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      q = t + dy;
      if (q < 0 || q >= h || q > r || r - q > 2) continue;
      sl = (s + NUM_SLOTS - (r - q)) % NUM_SLOTS;
      for (int dx = -1; dx <= 1; dx++) begin
        p = x + dx;
        if (p < 0 || p >= w) continue;
        sr += lines[sl][p].in_red;
        sg += lines[sl][p].in_green;
        sb += lines[sl][p].in_blue;
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    o = '0;
    o.out_red   = 8'((2 * sr + cnt) / (2 * cnt));
    o.out_green = 8'((2 * sg + cnt) / (2 * cnt));
    o.out_blue  = 8'((2 * sb + cnt) / (2 * cnt));
    return o;
  endfunction

  // Called at the edge an item is accepted; queues the results it releases.
  task automatic predict_blur(input in_pixel_t px);
    int w, h, r, c, s, nc, n;
    int cols [2];
    out_pixel_t res [4];
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                                                            : int'(height_reg);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    s = slot_pos;
    nc = 0;
    n = 0;
    lines[s][c] = px;
    // left neighbor column is complete now; the row end also closes its own
    if (c >= 1) begin
      cols[nc] = c - 1;
      nc++;
    end
    if (c == w - 1) begin
      cols[nc] = c;
      nc++;
    end
    // emit the row above per column; the last row also emits the row itself as a pair
    for (int i = 0; i < nc; i++) begin
      if (r >= 1) begin
        res[n] = blur_at(r - 1, cols[i], r, s, w, h);
        n++;
      end
      if (r == h - 1) begin
        res[n] = blur_at(r, cols[i], r, s, w, h);
        n++;
      end
    end
    if (n > 0) begin
      res[n-1].last_of_run = 1'b1;
      if (r == h - 1 && c == w - 1) res[n-1].image_done = 1'b1;
    end
    for (int i = 0; i < n; i++) blurred_q.push_back(res[i]);
    if (c == w - 1) begin
      col_pos  = 0;
      slot_pos = (s + 1) % NUM_SLOTS;
      row_pos  = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blurred_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h at cycle %0d", out_data, cycles);
      end else begin
        want = blurred_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: exp rgb %h %h %h last %b done %b,"
                     , cycles, want.out_red, want.out_green, want.out_blue,
                     want.last_of_run, want.image_done,
                     " got rgb %h %h %h last %b done %b",
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.last_of_run, out_data.image_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      stall_left = recv_calm ? 0 : $urandom_range(0, 19);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= !rst_n || (hold_off > 1) || (stall_left > 0);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_blur_3x3_edge_aware regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; returns at the edge it is taken.
  // in_valid stays high so a back-to-back item needs no extra edge.
  task automatic send_pixel(input in_pixel_t px);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    predict_blur(px);
  endtask

  function automatic in_pixel_t rand_pixel();
    return in_pixel_t'(24'($urandom_range(0, 24'hFF_FFFF)));
  endfunction

  // Stop offering, then wait for the block to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register write; only called with the block idle (after drain).
  // cfg_valid is dropped by the caller after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WID_W-1:0];
    else height_reg = val;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_image(input int w, input int h);
    for (int i = 0; i < w * h; i++) send_pixel(rand_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size (1024 x 768): the first row yields nothing, then restart.
  task automatic test_reset_size();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hAA55AA);
    drain();
  endtask

  // Small full images with extreme values, a single row, a single pixel,
  // zero and oversized registers.
  task automatic test_directed();
    in_pixel_t pat [9];
    pat = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h55AA55,
            24'hFFFFFF, 24'h000000, 24'hAA55AA, 24'h010203};
    set_size(3, 3);
    foreach (pat[i]) send_pixel(pat[i]);
    drain();
    // one row: each item after the first releases its left neighbor, the last also its own
    set_size(4, 1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    drain();
    // zero width and height act as one: a single-pixel image
    set_size(0, 0);
    send_pixel(24'h7F80FF);
    send_pixel(24'h80017E);
    drain();
    // oversized registers clamp to the maxima; a few items, then restart
    set_size(2047, 8191);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    drain();
    // height at its maximum, two-column image, a few rows only
    set_size(2, 4096);
    repeat (6) send_pixel(rand_pixel());
    drain();
  endtask

  // Mostly complete images of random size, some back to back (wrap into a
  // new image), some cut short before a restart.
  task automatic test_random_images();
    int sent, w, h, n;
    sent = 0;
    while (sent < 70) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      set_size(w, h);
      n = w * h;
      if ($urandom_range(0, 3) == 0) n = 2 * n;           // wrap into a second image
      if ($urandom_range(0, 6) == 0) n = $urandom_range(1, w * h);  // cut short
      if (n > 70 - sent) n = 70 - sent;
      for (int i = 0; i < n; i++) send_pixel(rand_pixel());
      sent += n;
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    set_size(5, 4);
    @(posedge clk);
    hold_off <= 400;
    send_calm = 1'b1;
    send_image(5, 4);
    drain();
  endtask

  // Full width, a single row: a short stretch of the row, then restart.
  task automatic test_full_width();
    set_size(MAX_WIDTH, 1);
    repeat (8) send_pixel(rand_pixel());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_directed();
    test_random_images();
    test_backpressure();
    test_full_width();
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("box_blur_3x3_edge_aware regression: pass");
    end else begin
      $display("box_blur_3x3_edge_aware regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ram.sv
hw/rtl/bb3_ctrl.sv
hw/rtl/bb3_dpath.sv
hw/rtl/box_blur_3x3_edge_aware.sv
tb/sv/tb.sv
